@@ hw/rtl/vsc_pkg.sv @@
package vsc_pkg;

   // parser phases
   localparam logic [3:0] PH_LEAD    = 4'd0;
   localparam logic [3:0] PH_AFTER_V = 4'd1;
   localparam logic [3:0] PH_MAJOR   = 4'd2;
   localparam logic [3:0] PH_DOT     = 4'd3;
   localparam logic [3:0] PH_MINOR   = 4'd4;
   localparam logic [3:0] PH_SUFFIX  = 4'd5;
   localparam logic [3:0] PH_TRAIL   = 4'd6;
   localparam logic [3:0] PH_DONE    = 4'd7;
   localparam logic [3:0] PH_BAD_RUN = 4'd8;
   localparam logic [3:0] PH_BAD_END = 4'd9;

   // first text difference
   localparam logic [1:0] TXT_UNDECIDED = 2'd0;
   localparam logic [1:0] TXT_GREATER   = 2'd1;
   localparam logic [1:0] TXT_EQUAL     = 2'd2;
   localparam logic [1:0] TXT_LESS      = 2'd3;

   // result order codes
   localparam logic signed [1:0] ORD_LESS    = -2'sd1;
   localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
   localparam logic signed [1:0] ORD_GREATER = 2'sd1;

   localparam logic [7:0] CH_END   = 8'd0;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_DOT   = 8'd46;
   localparam logic [7:0] CH_LOW_V = 8'd118;
   localparam logic [7:0] CH_UP_V  = 8'd86;
   localparam logic [7:0] CH_LOW_A_BASE = 8'd96;

   typedef logic [7:0] char_type;
   typedef logic signed [1:0] order_type;

   typedef struct packed {
      logic [3:0]  phase;
      logic [31:0] major;
      logic [31:0] minor;
      logic [63:0] rank;
   } parse_type;

endpackage

@@ hw/rtl/vsc_req_if.sv @@
interface vsc_req_if;
   import vsc_pkg::*;

   logic     valid;
   logic     ready;
   char_type left_char;
   char_type right_char;
   logic     last;

   modport source (output valid, output left_char, output right_char, output last,
                   input ready);
   modport sink (input valid, input left_char, input right_char, input last,
                 output ready);
endinterface

@@ hw/rtl/vsc_rsp_if.sv @@
interface vsc_rsp_if;
   import vsc_pkg::*;

   logic      valid;
   logic      ready;
   order_type order;
   logic      text_fallback;

   modport source (output valid, output order, output text_fallback, input ready);
   modport sink (input valid, input order, input text_fallback, output ready);
endinterface

@@ hw/rtl/version_string_comparator.sv @@
// A request with last set gives its response valid after the input register, parser
// update, compare and response registers, later while the response stalls.
// Throughput: one request per cycle while req_ch.ready is high; parser state updates
// per request. A response waiting on rsp_ch does not block requests until the compare
// stage is full. Reset (synchronous, active high) empties the pipeline and returns both
// parsers to the leading-space phase with cleared numbers and an undecided text order.
module version_string_comparator (
   input logic clock,
   input logic reset,
   vsc_req_if.sink   req_ch,
   vsc_rsp_if.source rsp_ch
);
   import vsc_pkg::*;

   function automatic logic is_space(char_type c);
      return c inside {8'd32, [8'd9:8'd13]};
   endfunction

   function automatic logic is_digit(char_type c);
      return c inside {[8'd48:8'd57]};
   endfunction

   function automatic logic is_alpha(char_type c);
      return c inside {[8'd65:8'd90], [8'd97:8'd122]};
   endfunction

   function automatic char_type fold(char_type c);
      return (c inside {[8'd65:8'd90]}) ? c + 8'd32 : c;
   endfunction

   function automatic logic has_ended(logic [3:0] ph);
      return ph == PH_DONE || ph == PH_BAD_END;
   endfunction

   function automatic parse_type advance(parse_type s, char_type c);
      parse_type   n;
      logic [3:0]  bad;
      logic [7:0]  digit;
      logic [7:0]  letter;
      logic [35:0] maj_acc;
      logic [35:0] min_acc;
      logic [68:0] rank_acc;
      n       = s;
      bad     = (c == CH_END) ? PH_BAD_END : PH_BAD_RUN;
      digit   = c - CH_ZERO;
      letter  = fold(c) - CH_LOW_A_BASE;
      maj_acc = {4'd0, s.major} * 36'd10 + {28'd0, digit};
      min_acc = {4'd0, s.minor} * 36'd10 + {28'd0, digit};
      rank_acc = {5'd0, s.rank} * 69'd26 + {64'd0, letter[4:0]};
      case (s.phase)
         PH_LEAD: begin
            if (is_space(c)) n.phase = PH_LEAD;
            else if (c == CH_LOW_V || c == CH_UP_V) n.phase = PH_AFTER_V;
            else if (is_digit(c)) begin
               n.major = {24'd0, digit};
               n.phase = PH_MAJOR;
            end else n.phase = bad;
         end
         PH_AFTER_V: begin
            if (is_digit(c)) begin
               n.major = {24'd0, digit};
               n.phase = PH_MAJOR;
            end else n.phase = bad;
         end
         PH_MAJOR: begin
            if (is_digit(c)) begin
               if (maj_acc[35:32] != 4'd0) n.phase = PH_BAD_RUN;
               else n.major = maj_acc[31:0];
            end else if (c == CH_DOT) n.phase = PH_DOT;
            else n.phase = bad;
         end
         PH_DOT: begin
            if (is_digit(c)) begin
               n.minor = {24'd0, digit};
               n.phase = PH_MINOR;
            end else n.phase = bad;
         end
         PH_MINOR, PH_SUFFIX: begin
            if (s.phase == PH_MINOR && is_digit(c)) begin
               if (min_acc[35:32] != 4'd0) n.phase = PH_BAD_RUN;
               else n.minor = min_acc[31:0];
            end else if (is_alpha(c)) begin
               if (rank_acc[68:64] != 5'd0) n.phase = PH_BAD_RUN;
               else begin
                  n.rank  = rank_acc[63:0];
                  n.phase = PH_SUFFIX;
               end
            end else if (is_space(c)) n.phase = PH_TRAIL;
            else if (c == CH_END) n.phase = PH_DONE;
            else n.phase = PH_BAD_RUN;
         end
         PH_TRAIL: begin
            if (is_space(c)) n.phase = PH_TRAIL;
            else if (c == CH_END) n.phase = PH_DONE;
            else n.phase = PH_BAD_RUN;
         end
         PH_BAD_RUN: begin
            if (c == CH_END) n.phase = PH_BAD_END;
         end
         default: begin
            n = s;
         end
      endcase
      return n;
   endfunction

   // string is complete if it could end right here
   function automatic logic can_end(logic [3:0] ph);
      return ph inside {PH_MINOR, PH_SUFFIX, PH_TRAIL, PH_DONE};
   endfunction

   function automatic logic [1:0] text_step(logic [1:0] t, char_type lc, char_type rc);
      logic [1:0] n;
      n = t;
      if (t == TXT_UNDECIDED) begin
         if (lc != CH_END && rc != CH_END) begin
            if (fold(lc) != fold(rc))
               n = (fold(lc) > fold(rc)) ? TXT_GREATER : TXT_LESS;
         end else if (lc == CH_END && rc == CH_END) n = TXT_EQUAL;
         else n = (lc == CH_END) ? TXT_LESS : TXT_GREATER;
      end
      return n;
   endfunction

   function automatic order_type cmp64(logic [63:0] a, logic [63:0] b);
      if (a == b) return ORD_EQUAL;
      return (a > b) ? ORD_GREATER : ORD_LESS;
   endfunction

   localparam parse_type PARSE_INIT = '{phase: PH_LEAD, major: 32'd0, minor: 32'd0,
                                        rank: 64'd0};

   // input register
   logic     s1_valid_ff, s1_valid_in;
   char_type s1_left_ff, s1_right_ff;
   logic     s1_last_ff;

   // parser state
   parse_type  left_ff, left_in, right_ff, right_in;
   logic [1:0] text_ff, text_in;

   // compare stage
   logic        cmp_valid_ff, cmp_valid_in;
   logic        cmp_left_ok_ff, cmp_right_ok_ff;
   logic [31:0] cmp_left_major_ff, cmp_left_minor_ff;
   logic [31:0] cmp_right_major_ff, cmp_right_minor_ff;
   logic [63:0] cmp_left_rank_ff, cmp_right_rank_ff;
   logic [1:0]  cmp_text_ff;

   // response register
   logic      rsp_valid_ff, rsp_valid_in;
   order_type rsp_order_ff, rsp_order_in;
   logic      rsp_fallback_ff, rsp_fallback_in;

   logic      out_ready, cmp_adv, cmp_ready, s1_go, req_take;
   char_type  lc, rc;
   parse_type left_step, right_step;
   logic [1:0] text_step_val;
   order_type ord_major, ord_minor, ord_rank;

   assign out_ready = !rsp_valid_ff || rsp_ch.ready;
   assign cmp_adv   = cmp_valid_ff && out_ready;
   assign cmp_ready = !cmp_valid_ff || out_ready;
   assign s1_go     = s1_valid_ff && (!s1_last_ff || cmp_ready);
   assign req_take  = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !s1_valid_ff || s1_go;

   // drop characters of a string that already ended
   assign lc = has_ended(left_ff.phase) ? CH_END : s1_left_ff;
   assign rc = has_ended(right_ff.phase) ? CH_END : s1_right_ff;

   assign left_step     = advance(left_ff, lc);
   assign right_step    = advance(right_ff, rc);
   assign text_step_val = text_step(text_ff, lc, rc);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) s1_valid_in = 1'b1;
      else if (s1_go) s1_valid_in = 1'b0;

      left_in  = left_ff;
      right_in = right_ff;
      text_in  = text_ff;
      if (s1_go) begin
         if (s1_last_ff) begin
            left_in  = PARSE_INIT;
            right_in = PARSE_INIT;
            text_in  = TXT_UNDECIDED;
         end else begin
            left_in  = left_step;
            right_in = right_step;
            text_in  = text_step_val;
         end
      end

      cmp_valid_in = cmp_valid_ff;
      if (s1_go && s1_last_ff) cmp_valid_in = 1'b1;
      else if (cmp_adv) cmp_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (cmp_adv) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   assign ord_major = cmp64({32'd0, cmp_left_major_ff}, {32'd0, cmp_right_major_ff});
   assign ord_minor = cmp64({32'd0, cmp_left_minor_ff}, {32'd0, cmp_right_minor_ff});
   assign ord_rank  = cmp64(cmp_left_rank_ff, cmp_right_rank_ff);

   always_comb begin
      if (cmp_left_ok_ff && cmp_right_ok_ff) begin
         rsp_fallback_in = 1'b0;
         if (ord_major != ORD_EQUAL) rsp_order_in = ord_major;
         else if (ord_minor != ORD_EQUAL) rsp_order_in = ord_minor;
         else rsp_order_in = ord_rank;
      end else begin
         rsp_fallback_in = 1'b1;
         case (cmp_text_ff)
            TXT_GREATER: rsp_order_in = ORD_GREATER;
            TXT_LESS:    rsp_order_in = ORD_LESS;
            default:     rsp_order_in = ORD_EQUAL;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         left_ff      <= PARSE_INIT;
         right_ff     <= PARSE_INIT;
         text_ff      <= TXT_UNDECIDED;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         text_ff      <= text_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_left_ff  <= req_ch.left_char;
         s1_right_ff <= req_ch.right_char;
         s1_last_ff  <= req_ch.last;
      end
      // snapshot the finished pair; both strings end after this request
      if (s1_go && s1_last_ff) begin
         cmp_left_ok_ff     <= can_end(left_step.phase);
         cmp_right_ok_ff    <= can_end(right_step.phase);
         cmp_left_major_ff  <= left_step.major;
         cmp_left_minor_ff  <= left_step.minor;
         cmp_left_rank_ff   <= left_step.rank;
         cmp_right_major_ff <= right_step.major;
         cmp_right_minor_ff <= right_step.minor;
         cmp_right_rank_ff  <= right_step.rank;
         cmp_text_ff        <= text_step_val;
      end
      if (cmp_adv) begin
         rsp_order_ff    <= rsp_order_in;
         rsp_fallback_ff <= rsp_fallback_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.order         = rsp_order_ff;
   assign rsp_ch.text_fallback = rsp_fallback_ff;

endmodule

@@ hw/rtl/vsc_checker.sv @@
module vsc_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    req_last,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input vsc_pkg::order_type      rsp_order
);
   import vsc_pkg::*;

   // pairs accepted whose response has not been taken yet
   logic [2:0] pending_ff, pending_in;
   logic       last_take, rsp_take;

   assign last_take = req_valid && req_ready && req_last;
   assign rsp_take  = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (last_take && !rsp_take) pending_in = pending_ff + 3'd1;
      else if (!last_take && rsp_take) pending_in = pending_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) pending_ff <= 3'd0;
      else pending_ff <= pending_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_order))
      else $error("response dropped or changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without a finished pair");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      last_take && pending_ff == 3'd0 |-> ##3 rsp_valid)
      else $error("response late on an empty pipeline");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_order_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_order == ORD_LESS || rsp_order == ORD_EQUAL
                    || rsp_order == ORD_GREATER)
      else $error("order code out of range");

endmodule

bind version_string_comparator vsc_checker u_vsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_last  (req_ch.last),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_order (rsp_ch.order)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import vsc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          MAX_REPORTS = 10;
   localparam int          PHASE_CHARS = 275;
   localparam logic [31:0] U32_MAX     = 32'hFFFF_FFFF;
   localparam logic [63:0] U64_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam char_type    CH_TAB      = 8'd9;
   localparam char_type    CH_CR       = 8'd13;
   localparam char_type    CH_SPACE    = 8'd32;
   localparam char_type    CH_NINE     = 8'd57;
   localparam char_type    CH_UP_A     = 8'd65;
   localparam char_type    CH_UP_Z     = 8'd90;
   localparam char_type    CH_LOW_A    = 8'd97;
   localparam char_type    CH_LOW_Z    = 8'd122;
   localparam char_type    CASE_BIT    = 8'h20;

   typedef char_type text_q[$];

   typedef struct packed {
      char_type left;
      char_type right;
      logic     last;
   } char_pair;

   typedef struct packed {
      order_type order;
      logic      fallback;
   } order_verdict;

   logic clock;
   logic reset;

   vsc_req_if req_if();
   vsc_rsp_if rsp_if();

   version_string_comparator DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   char_pair     pending_chars[$];
   order_verdict due_orders[$];

   parse_type   left_parse;
   parse_type   right_parse;
   logic [1:0]  first_diff;

   int          chars_queued = 0;
   int          chars_sent = 0;
   int          orders_checked = 0;
   int          by_number = 0;
   int          by_text = 0;
   int          mismatches = 0;
   int          idle_pct;
   int          stall_pct;
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------- character classes and parser ----------------

   function automatic bit is_space(char_type c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic bit is_digit(char_type c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_upper(char_type c);
      return c >= CH_UP_A && c <= CH_UP_Z;
   endfunction

   function automatic bit is_alpha(char_type c);
      return is_upper(c) || (c >= CH_LOW_A && c <= CH_LOW_Z);
   endfunction

   function automatic char_type fold_case(char_type c);
      return is_upper(c) ? (c | CASE_BIT) : c;
   endfunction

   function automatic bit has_ended(logic [3:0] ph);
      return ph == PH_DONE || ph == PH_BAD_END;
   endfunction

   function automatic order_type rank_cmp(logic [63:0] a, logic [63:0] b);
      if (a == b) return ORD_EQUAL;
      return (a > b) ? ORD_GREATER : ORD_LESS;
   endfunction

   function automatic bit digit_fits(logic [31:0] v, char_type c);
      logic [31:0] d;
      d = {24'd0, c - CH_ZERO};
      return v <= (U32_MAX - d) / 32'd10;
   endfunction

   function automatic parse_type parse_step(parse_type st, char_type c);
      logic [3:0]  bad;
      logic [31:0] digit;
      logic [63:0] letter;
      bad = (c == CH_END) ? PH_BAD_END : PH_BAD_RUN;
      digit = {24'd0, c - CH_ZERO};
      letter = {56'd0, fold_case(c) - CH_LOW_A_BASE};
      case (st.phase)
         PH_LEAD: begin
            if (c == CH_LOW_V || c == CH_UP_V) begin
               st.phase = PH_AFTER_V;
            end else if (is_digit(c)) begin
               st.major = digit;
               st.phase = PH_MAJOR;
            end else if (!is_space(c)) begin
               st.phase = bad;
            end
         end
         PH_AFTER_V: begin
            if (is_digit(c)) begin
               st.major = digit;
               st.phase = PH_MAJOR;
            end else begin
               st.phase = bad;
            end
         end
         PH_MAJOR: begin
            if (is_digit(c)) begin
               if (digit_fits(st.major, c)) st.major = st.major * 32'd10 + digit;
               else st.phase = PH_BAD_RUN;
            end else if (c == CH_DOT) begin
               st.phase = PH_DOT;
            end else begin
               st.phase = bad;
            end
         end
         PH_DOT: begin
            if (is_digit(c)) begin
               st.minor = digit;
               st.phase = PH_MINOR;
            end else begin
               st.phase = bad;
            end
         end
         PH_MINOR, PH_SUFFIX: begin
            if (st.phase == PH_MINOR && is_digit(c)) begin
               if (digit_fits(st.minor, c)) st.minor = st.minor * 32'd10 + digit;
               else st.phase = PH_BAD_RUN;
            end else if (is_alpha(c)) begin
               // base-26 rank, drop to bad when it would pass 64 bits
               if (st.rank > (U64_MAX - letter) / 64'd26) begin
                  st.phase = PH_BAD_RUN;
               end else begin
                  st.rank = st.rank * 64'd26 + letter;
                  st.phase = PH_SUFFIX;
               end
            end else if (is_space(c)) begin
               st.phase = PH_TRAIL;
            end else if (c == CH_END) begin
               st.phase = PH_DONE;
            end else begin
               st.phase = PH_BAD_RUN;
            end
         end
         PH_TRAIL: begin
            if (c == CH_END) st.phase = PH_DONE;
            else if (!is_space(c)) st.phase = PH_BAD_RUN;
         end
         PH_BAD_RUN: begin
            if (c == CH_END) st.phase = PH_BAD_END;
         end
         default: begin
         end
      endcase
      return st;
   endfunction

   task automatic clear_compare();
      left_parse = '0;
      left_parse.phase = PH_LEAD;
      right_parse = '0;
      right_parse.phase = PH_LEAD;
      first_diff = TXT_UNDECIDED;
   endtask

   // Fold one accepted request into the running comparison; queue the order on last.
   task automatic track_chars(char_type lraw, char_type rraw, logic fin);
      char_type     lc;
      char_type     rc;
      order_verdict v;
      lc = has_ended(left_parse.phase) ? CH_END : lraw;
      rc = has_ended(right_parse.phase) ? CH_END : rraw;
      if (first_diff == TXT_UNDECIDED) begin
         if (lc != CH_END && rc != CH_END) begin
            if (fold_case(lc) != fold_case(rc))
               first_diff = (fold_case(lc) > fold_case(rc)) ? TXT_GREATER : TXT_LESS;
         end else if (lc == CH_END && rc == CH_END) begin
            first_diff = TXT_EQUAL;
         end else begin
            first_diff = (lc == CH_END) ? TXT_LESS : TXT_GREATER;
         end
      end
      left_parse = parse_step(left_parse, lc);
      right_parse = parse_step(right_parse, rc);
      if (fin) begin
         // both strings end right after the last position
         left_parse = parse_step(left_parse, CH_END);
         right_parse = parse_step(right_parse, CH_END);
         if (left_parse.phase == PH_DONE && right_parse.phase == PH_DONE) begin
            v.order = rank_cmp({32'd0, left_parse.major}, {32'd0, right_parse.major});
            if (v.order == ORD_EQUAL)
               v.order = rank_cmp({32'd0, left_parse.minor}, {32'd0, right_parse.minor});
            if (v.order == ORD_EQUAL)
               v.order = rank_cmp(left_parse.rank, right_parse.rank);
            v.fallback = 1'b0;
            by_number++;
         end else begin
            case (first_diff)
               TXT_GREATER: v.order = ORD_GREATER;
               TXT_LESS:    v.order = ORD_LESS;
               default:     v.order = ORD_EQUAL;
            endcase
            v.fallback = 1'b1;
            by_text++;
         end
         due_orders.push_back(v);
         clear_compare();
      end
   endtask

   // ---------------- stimulus generation ----------------

   function automatic text_q str_bytes(string s);
      text_q q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic char_type pick_space();
      int r;
      r = $urandom_range(6);
      return (r == 6) ? CH_SPACE : char_type'(CH_TAB + r);
   endfunction

   function automatic text_q noise_text();
      text_q q;
      repeat ($urandom_range(8)) q.push_back(char_type'($urandom_range(255, 1)));
      return q;
   endfunction

   function automatic text_q number_text();
      longint unsigned value;
      string           digits;
      case ($urandom_range(9))
         0, 1, 2, 3: value = $urandom_range(9);
         4, 5:       value = $urandom_range(999);
         6:          value = $urandom;
         // straddle the 32-bit limit
         7:          value = 64'd4294967290 + $urandom_range(10);
         8:          value = {$urandom, $urandom} % 64'd100_000_000_000;
         default:    value = $urandom_range(20);
      endcase
      digits = $sformatf("%0d", value);
      if ($urandom_range(9) == 0) digits = {"0", digits};
      return str_bytes(digits);
   endfunction

   function automatic text_q make_version();
      text_q    q;
      int       r;
      int       letters;
      bit       all_z;
      char_type ch;
      repeat (($urandom_range(9) < 3) ? $urandom_range(2, 1) : 0) q.push_back(pick_space());
      if ($urandom_range(9) < 3) q.push_back($urandom_range(1) ? CH_LOW_V : CH_UP_V);
      q = {q, number_text()};
      q.push_back(CH_DOT);
      q = {q, number_text()};
      // long suffixes sit around the 64-bit rank limit
      r = $urandom_range(19);
      letters = (r < 10) ? 0 : (r < 17) ? $urandom_range(3, 1) : $urandom_range(15, 12);
      all_z = letters > 11 && $urandom_range(2) == 0;
      repeat (letters) begin
         ch = all_z ? CH_LOW_Z : char_type'(CH_LOW_A + $urandom_range(25));
         if ($urandom_range(1)) ch = ch ^ CASE_BIT;
         q.push_back(ch);
      end
      repeat (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0) q.push_back(pick_space());
      return q;
   endfunction

   // Past the end of a string: one end marker, then zeros or junk the block must ignore.
   function automatic char_type text_at(text_q s, int i, bit junk);
      if (i < s.size()) return s[i];
      if (i == s.size() || !junk) return CH_END;
      return char_type'($urandom_range(255, 1));
   endfunction

   task automatic push_pair(text_q lft, text_q rgt, int n, bit junk);
      char_pair item;
      for (int i = 0; i < n; i++) begin
         item.left = text_at(lft, i, junk);
         item.right = text_at(rgt, i, junk);
         item.last = (i == n - 1);
         pending_chars.push_back(item);
         chars_queued++;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_chars.size() != 0 || req_if.valid || due_orders.size() != 0);
   endtask

   task automatic run_phase(int idle, int stall, int budget);
      int target;
      @(negedge clock);
      idle_pct = idle;
      stall_pct = stall;
      target = chars_queued + budget;
      while (chars_queued < target) begin
         text_q lft;
         text_q rgt;
         text_q tmp;
         int    kind;
         int    pos;
         int    longest;
         int    n;
         kind = $urandom_range(19);
         lft = make_version();
         if (kind < 9) begin
            // near copy: runs the text order deep into the strings
            rgt = lft;
            pos = $urandom_range(rgt.size() - 1);
            case ($urandom_range(5))
               1: begin
                  if (is_alpha(rgt[pos])) rgt[pos] = rgt[pos] ^ CASE_BIT;
                  else rgt[pos] = char_type'(CH_ZERO + $urandom_range(9));
               end
               2: rgt[pos] = char_type'(CH_ZERO + $urandom_range(9));
               3: rgt.push_back(char_type'(CH_LOW_A + $urandom_range(25)));
               4: rgt.insert(pos, char_type'($urandom_range(255, 1)));
               5: rgt.delete(pos);
               default: begin
               end
            endcase
         end else if (kind < 15) begin
            rgt = make_version();
         end else if (kind < 17) begin
            rgt = noise_text();
         end else if (kind == 17) begin
            rgt.delete();
         end else begin
            rgt = lft;
            lft = noise_text();
         end
         if ($urandom_range(1)) begin
            tmp = lft;
            lft = rgt;
            rgt = tmp;
         end
         longest = (lft.size() > rgt.size()) ? lft.size() : rgt.size();
         n = (longest > 0 && $urandom_range(6) == 0) ? $urandom_range(longest, 1)
                                                      : longest + 1 + $urandom_range(2);
         push_pair(lft, rgt, n, $urandom_range(1));
      end
      wait_drained();
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      char_pair nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            track_chars(req_if.left_char, req_if.right_char, req_if.last);
            chars_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct) begin
               nxt = pending_chars.pop_front();
               req_if.valid <= 1'b1;
               req_if.left_char <= nxt.left;
               req_if.right_char <= nxt.right;
               req_if.last <= nxt.last;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      order_verdict want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            orders_checked++;
            if (due_orders.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response: order %0d text_fallback %0b",
                           rsp_if.order, rsp_if.text_fallback);
            end else begin
               want = due_orders.pop_front();
               if (rsp_if.order !== want.order || rsp_if.text_fallback !== want.fallback) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("response %0d: order exp %0d got %0d, text_fallback exp %0b got %0b",
                              orders_checked, want.order, rsp_if.order,
                              want.fallback, rsp_if.text_fallback);
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------- sequence ----------------

   initial begin
      text_q nothing;
      text_q top_byte;
      text_q high_byte;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.left_char = CH_END;
      req_if.right_char = CH_END;
      req_if.last = 1'b0;
      rsp_if.ready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      clear_compare();
      top_byte.push_back(8'hFF);
      high_byte.push_back(8'h80);

      // both empty, empty against text, spaces/v/case fold, bytes with the top bit set,
      // truncated string against one with junk after its end, plain minor compare
      push_pair(nothing, nothing, 1, 1'b0);
      push_pair(nothing, str_bytes("1.0"), 1, 1'b0);
      push_pair(str_bytes(" v9.9z\t"), str_bytes("V9.9Z "), 8, 1'b0);
      push_pair(top_byte, high_byte, 1, 1'b0);
      push_pair(str_bytes("2.1bcd"), str_bytes("2.1"), 5, 1'b1);
      push_pair(str_bytes("3.07"), str_bytes("3.8"), 5, 1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // hold the sender until every directed order is back
      wait_drained();

      run_phase(0, 0, PHASE_CHARS);
      run_phase(57, 0, PHASE_CHARS);
      run_phase(0, 57, PHASE_CHARS);
      run_phase(26, 26, PHASE_CHARS);

      repeat (8) @(negedge clock);
      $display("%0d character pairs sent, %0d version orders checked", chars_sent,
               orders_checked);
      $display("%0d decided by number, %0d by text fallback", by_number, by_text);
      if (mismatches == 0 && due_orders.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
